// ===== sv/voxel_ray_dda_traversal_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Voxel ray DDA traversal assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef VOXEL_RAY_DDA_TRAVERSAL_UNIT_DEFINES_SVH
`define VOXEL_RAY_DDA_TRAVERSAL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define VRDDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vrdda assertion failed");

// Next-cycle implication.
`define VRDDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vrdda assertion failed");

`endif

// ===== sv/vrdda_pkg.sv =====
// ---------------------------------------------------------------------------
// Voxel ray DDA traversal package
// Word types of the request and result channels and fixed codes.
// ---------------------------------------------------------------------------
package vrdda_pkg;

    localparam int COORD_W = 32;
    localparam int CFG_W   = 32;
    localparam int T_OUT_W = 40;

    localparam logic [CFG_W-1:0] CELL_SIZE_RESET = 32'd65536;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } t_req;

    typedef struct packed {
        logic [1:0]                stepped_axis;
        logic signed [COORD_W-1:0] cell_x;
        logic signed [COORD_W-1:0] cell_y;
        logic signed [COORD_W-1:0] cell_z;
        logic [T_OUT_W-1:0]        t_now;
    } t_res;

endpackage

// ===== sv/vrdda_div.sv =====
// ---------------------------------------------------------------------------
// Voxel ray DDA restoring divider
// Unsigned divider, one quotient bit per cycle, with remainder.
// ---------------------------------------------------------------------------
module vrdda_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic [DVS_W-1:0] n_rem;
    logic             q_bit;

    always_comb begin
        rem_sh = {r_rem, r_quot[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        q_bit  = ~diff[DVS_W];
        n_rem  = q_bit ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[DVD_W-2:0], q_bit};
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== sv/voxel_ray_dda_traversal_unit.sv =====
// ---------------------------------------------------------------------------
// Voxel ray DDA traversal unit
// Amanatides-Woo grid traversal of a ray in signed fixed point.
// ---------------------------------------------------------------------------
// A step word is taken when the block is idle and its result is
// registered in the next cycle, so steps run one per cycle as long as results
// are taken. A start word runs through one shared restoring divider, one
// quotient bit per cycle: per axis a floor division of the origin by the cell
// size and, unless that direction is zero, the boundary and per-cell
// distances. No word is accepted while a start runs. Distances saturate at
// all ones, which stands for infinity; cell indices wrap.
`include "voxel_ray_dda_traversal_unit_defines.svh"

module voxel_ray_dda_traversal_unit
    import vrdda_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int T_WIDTH   = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_res             o_res
);

    localparam int DVD_W = COORD_W + FRAC_BITS;
    localparam int SAT_W = (DVD_W > T_WIDTH) ? DVD_W : T_WIDTH;
    localparam logic [T_WIDTH-1:0] T_MAX = {T_WIDTH{1'b1}};

    localparam logic [1:0] PH_ORG = 2'd0;
    localparam logic [1:0] PH_BND = 2'd1;
    localparam logic [1:0] PH_PER = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAUNCH = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_cell_size;
    t_req               r_req;
    t_res               r_res;
    logic               r_out_valid;
    logic [1:0]         r_axis;
    logic [1:0]         r_phase;
    logic [COORD_W-1:0] r_rem_fl;
    logic [COORD_W-1:0] r_cell [3];
    logic               r_neg  [3];
    logic [T_WIDTH-1:0] r_tnb  [3];
    logic [T_WIDTH-1:0] r_tpc  [3];

    logic               in_acc;
    logic               out_free;
    logic               res_load;
    logic [CFG_W-1:0]   cs_eff;

    // Step datapath
    logic [1:0]         step_axis;
    logic [T_WIDTH-1:0] step_t;
    logic [T_WIDTH-1:0] step_pc;
    logic [T_WIDTH:0]   step_sum;
    logic [T_WIDTH-1:0] n_tnb_step;
    logic [COORD_W-1:0] n_cell_step [3];

    // Start datapath
    logic [COORD_W-1:0] cur_org;
    logic [COORD_W-1:0] cur_dir;
    logic [COORD_W-1:0] org_mag;
    logic [COORD_W-1:0] dir_mag;
    logic [COORD_W-1:0] bnd_dist;
    logic [COORD_W-1:0] uq;
    logic [COORD_W-1:0] fl_q;
    logic [COORD_W-1:0] fl_rem;
    logic [SAT_W-1:0]   q_ext;
    logic [T_WIDTH-1:0] q_sat;

    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic [COORD_W-1:0] div_divisor;
    logic               div_done;
    logic [DVD_W-1:0]   div_quot;
    logic [COORD_W-1:0] div_rem;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cs_eff     = (r_cell_size == '0) ? CFG_W'(1) : r_cell_size;
    assign res_load   = (in_acc && (i_req.req_type == REQ_STEP)) ||
                        ((r_state == ST_FINISH) && out_free);

    // Least boundary distance wins; ties keep the lower axis.
    always_comb begin
        step_axis = AXIS_X;
        step_t    = r_tnb[0];
        step_pc   = r_tpc[0];
        if (r_tnb[1] < step_t) begin
            step_axis = AXIS_Y;
            step_t    = r_tnb[1];
            step_pc   = r_tpc[1];
        end
        if (r_tnb[2] < step_t) begin
            step_axis = AXIS_Z;
            step_t    = r_tnb[2];
            step_pc   = r_tpc[2];
        end
        step_sum   = {1'b0, step_t} + {1'b0, step_pc};
        n_tnb_step = step_sum[T_WIDTH] ? T_MAX : step_sum[T_WIDTH-1:0];
        for (int i = 0; i < 3; i++) begin
            if (step_axis == 2'(i)) begin
                n_cell_step[i] = r_neg[i] ? (r_cell[i] - COORD_W'(1))
                                          : (r_cell[i] + COORD_W'(1));
            end else begin
                n_cell_step[i] = r_cell[i];
            end
        end
    end

    always_comb begin
        case (r_axis)
            AXIS_X: begin
                cur_org = r_req.origin_x;
                cur_dir = r_req.dir_x;
            end
            AXIS_Y: begin
                cur_org = r_req.origin_y;
                cur_dir = r_req.dir_y;
            end
            default: begin
                cur_org = r_req.origin_z;
                cur_dir = r_req.dir_z;
            end
        endcase
        org_mag  = cur_org[COORD_W-1] ? (~cur_org + COORD_W'(1)) : cur_org;
        dir_mag  = cur_dir[COORD_W-1] ? (~cur_dir + COORD_W'(1)) : cur_dir;
        bnd_dist = cur_dir[COORD_W-1] ? r_rem_fl : (cs_eff - r_rem_fl);

        // Truncated quotient turned into floor division for a negative origin.
        uq = div_quot[COORD_W-1:0];
        if (!cur_org[COORD_W-1]) begin
            fl_q   = uq;
            fl_rem = div_rem;
        end else if (div_rem == '0) begin
            fl_q   = COORD_W'(0) - uq;
            fl_rem = '0;
        end else begin
            fl_q   = ~uq;
            fl_rem = cs_eff - div_rem;
        end

        q_ext = SAT_W'(div_quot);
        q_sat = (q_ext > SAT_W'(T_MAX)) ? T_MAX : T_WIDTH'(div_quot);

        case (r_phase)
            PH_ORG: begin
                div_dividend = DVD_W'(org_mag);
                div_divisor  = cs_eff;
            end
            PH_BND: begin
                div_dividend = {bnd_dist, {FRAC_BITS{1'b0}}};
                div_divisor  = dir_mag;
            end
            default: begin
                div_dividend = {cs_eff, {FRAC_BITS{1'b0}}};
                div_divisor  = dir_mag;
            end
        endcase
    end

    assign div_start = (r_state == ST_LAUNCH);

    vrdda_div #(
        .DVD_W (DVD_W),
        .DVS_W (COORD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cell_size <= CELL_SIZE_RESET;
            r_out_valid <= 1'b0;
            r_axis      <= AXIS_X;
            r_phase     <= PH_ORG;
            for (int i = 0; i < 3; i++) begin
                r_cell[i] <= '0;
                r_neg[i]  <= 1'b0;
                r_tnb[i]  <= T_MAX;
                r_tpc[i]  <= T_MAX;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cell_size <= i_cfg_wr_data;
            end
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_req.req_type == REQ_START) begin
                            r_req   <= i_req;
                            r_axis  <= AXIS_X;
                            r_phase <= PH_ORG;
                            r_state <= ST_LAUNCH;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_cell[i] <= n_cell_step[i];
                                if (step_axis == 2'(i)) begin
                                    r_tnb[i] <= n_tnb_step;
                                end
                            end
                            r_res.stepped_axis <= step_axis;
                            r_res.cell_x       <= n_cell_step[0];
                            r_res.cell_y       <= n_cell_step[1];
                            r_res.cell_z       <= n_cell_step[2];
                            r_res.t_now        <= T_OUT_W'(step_t);
                        end
                    end
                end
                ST_LAUNCH: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_done) begin
                        case (r_phase)
                            PH_ORG: begin
                                r_rem_fl <= fl_rem;
                                for (int i = 0; i < 3; i++) begin
                                    if (r_axis == 2'(i)) begin
                                        r_cell[i] <= fl_q;
                                        r_neg[i]  <= cur_dir[COORD_W-1];
                                        if (cur_dir == '0) begin
                                            r_tnb[i] <= T_MAX;
                                            r_tpc[i] <= T_MAX;
                                        end
                                    end
                                end
                                if (cur_dir != '0) begin
                                    r_phase <= PH_BND;
                                    r_state <= ST_LAUNCH;
                                end else if (r_axis == AXIS_Z) begin
                                    r_state <= ST_FINISH;
                                end else begin
                                    r_axis  <= r_axis + 2'd1;
                                    r_state <= ST_LAUNCH;
                                end
                            end
                            PH_BND: begin
                                for (int i = 0; i < 3; i++) begin
                                    if (r_axis == 2'(i)) begin
                                        r_tnb[i] <= q_sat;
                                    end
                                end
                                r_phase <= PH_PER;
                                r_state <= ST_LAUNCH;
                            end
                            default: begin
                                for (int i = 0; i < 3; i++) begin
                                    if (r_axis == 2'(i)) begin
                                        r_tpc[i] <= q_sat;
                                    end
                                end
                                r_phase <= PH_ORG;
                                if (r_axis == AXIS_Z) begin
                                    r_state <= ST_FINISH;
                                end else begin
                                    r_axis  <= r_axis + 2'd1;
                                    r_state <= ST_LAUNCH;
                                end
                            end
                        endcase
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_res.stepped_axis <= AXIS_NONE;
                        r_res.cell_x       <= r_cell[0];
                        r_res.cell_y       <= r_cell[1];
                        r_res.cell_z       <= r_cell[2];
                        r_res.t_now        <= '0;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // A busy sequencer never takes a word.
    `VRDDA_ASSERT_NOW(a_busy_stalls, r_state != ST_IDLE, o_in_stall)
    // An accepted step shows its result in the next cycle.
    `VRDDA_ASSERT_NEXT(a_step_result, in_acc && (i_req.req_type == REQ_STEP),
        o_out_valid && (o_res.stepped_axis != AXIS_NONE))
    // A start result always reports a zero entry distance.
    `VRDDA_ASSERT_NOW(a_start_t_zero, o_out_valid && (o_res.stepped_axis == AXIS_NONE),
        o_res.t_now == '0)
    // The divider only finishes while the sequencer waits for it.
    `VRDDA_ASSERT_NOW(a_div_done_wait, div_done, r_state == ST_WAIT)

endmodule

// ===== tb/vrdda_traversal_checker.sv =====
// ---------------------------------------------------------------------------
// Voxel ray DDA traversal checker
// Watches the request, result and register ports. It traces each accepted
// request word through its own copy of the grid walk and compares every
// result word with the oldest predicted one.
// ---------------------------------------------------------------------------
module vrdda_traversal_checker
    import vrdda_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_req             i_req,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_res             i_res,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    localparam int                 FRAC  = 16;
    localparam logic [T_OUT_W-1:0] T_INF = '1;

    logic [CFG_W-1:0]   cell_size_q;
    logic [COORD_W-1:0] cell_idx    [3];
    logic               heading_neg [3];
    logic [T_OUT_W-1:0] t_boundary  [3];
    logic [T_OUT_W-1:0] t_stride    [3];
    logic [T_OUT_W-1:0] t_entry;
    t_res               cells_due[$];
    int                 miss_count;
    int                 checked_count;

    // Ray distance to cover span_len along an axis moving mag per unit of t.
    function automatic logic [T_OUT_W-1:0] ray_span(longint unsigned span_len,
                                                    longint unsigned mag);
        logic [63:0] quo;
        quo = (span_len << FRAC) / mag;
        return (quo > T_INF) ? T_INF : quo[T_OUT_W-1:0];
    endfunction

    function automatic logic [T_OUT_W-1:0] span_sum(logic [T_OUT_W-1:0] a,
                                                    logic [T_OUT_W-1:0] b);
        logic [63:0] total;
        total = a + b;
        return (total > T_INF) ? T_INF : total[T_OUT_W-1:0];
    endfunction

    function automatic void clear_ray_state();
        for (int i = 0; i < 3; i++) begin
            cell_idx[i]    = '0;
            heading_neg[i] = 1'b0;
            t_boundary[i]  = T_INF;
            t_stride[i]    = T_INF;
        end
        t_entry = '0;
    endfunction

    function automatic void load_axis(logic [1:0] ax,
                                      logic signed [COORD_W-1:0] org,
                                      logic signed [COORD_W-1:0] dir);
        longint csz, o, d, q, rem, mag;
        o   = org;
        d   = dir;
        csz = cell_size_q;
        // A zero cell size behaves as one LSB.
        if (csz == 0)
            csz = 1;
        // Floor division: move a negative remainder into the cell below.
        q   = o / csz;
        rem = o - q * csz;
        if (rem < 0) begin
            q   = q - 1;
            rem = rem + csz;
        end
        cell_idx[ax]    = q[COORD_W-1:0];
        heading_neg[ax] = (d < 0);
        if (d == 0) begin
            t_boundary[ax] = T_INF;
            t_stride[ax]   = T_INF;
            return;
        end
        mag = (d < 0) ? -d : d;
        t_boundary[ax] = ray_span((d < 0) ? rem : csz - rem, mag);
        t_stride[ax]   = ray_span(csz, mag);
    endfunction

    function automatic t_res trace_word(t_req w);
        t_res       r;
        logic [1:0] ax;
        if (w.req_type == REQ_START) begin
            load_axis(AXIS_X, w.origin_x, w.dir_x);
            load_axis(AXIS_Y, w.origin_y, w.dir_y);
            load_axis(AXIS_Z, w.origin_z, w.dir_z);
            t_entry = '0;
            ax      = AXIS_NONE;
        end else begin
            // Nearest boundary wins; ties stay with the lower axis.
            ax = AXIS_X;
            if (t_boundary[AXIS_Y] < t_boundary[ax])
                ax = AXIS_Y;
            if (t_boundary[AXIS_Z] < t_boundary[ax])
                ax = AXIS_Z;
            cell_idx[ax]   = heading_neg[ax] ? cell_idx[ax] - 1'b1 : cell_idx[ax] + 1'b1;
            t_entry        = t_boundary[ax];
            t_boundary[ax] = span_sum(t_boundary[ax], t_stride[ax]);
        end
        r.stepped_axis = ax;
        r.cell_x       = cell_idx[AXIS_X];
        r.cell_y       = cell_idx[AXIS_Y];
        r.cell_z       = cell_idx[AXIS_Z];
        r.t_now        = t_entry;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        logic bad;
        if (!i_rst_n) begin
            clear_ray_state();
            cell_size_q = CELL_SIZE_RESET;
            cells_due.delete();
            miss_count    = 0;
            checked_count = 0;
        end else begin
            if (i_cfg_wr_en)
                cell_size_q = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                cells_due.push_back(trace_word(i_req));
            if (i_out_valid && !i_out_stall) begin
                if (cells_due.size() == 0) begin
                    if (miss_count < 10)
                        $display("unexpected result: axis %0d cell (%0d,%0d,%0d) t %h",
                                 i_res.stepped_axis, i_res.cell_x, i_res.cell_y,
                                 i_res.cell_z, i_res.t_now);
                    miss_count++;
                end else begin
                    want = cells_due.pop_front();
                    bad  = 1'b0;
                    if (i_res.stepped_axis !== want.stepped_axis)
                        bad = 1'b1;
                    if (i_res.cell_x !== want.cell_x)
                        bad = 1'b1;
                    if (i_res.cell_y !== want.cell_y)
                        bad = 1'b1;
                    if (i_res.cell_z !== want.cell_z)
                        bad = 1'b1;
                    if (i_res.t_now !== want.t_now)
                        bad = 1'b1;
                    if (bad) begin
                        if (miss_count < 10) begin
                            $display("mismatch %0d expected: axis %0d cell (%0d,%0d,%0d) t %h",
                                     checked_count, want.stepped_axis, want.cell_x,
                                     want.cell_y, want.cell_z, want.t_now);
                            $display("mismatch %0d actual:   axis %0d cell (%0d,%0d,%0d) t %h",
                                     checked_count, i_res.stepped_axis, i_res.cell_x,
                                     i_res.cell_y, i_res.cell_z, i_res.t_now);
                        end
                        miss_count++;
                    end
                    checked_count++;
                end
            end
        end
        o_fail_count <= miss_count;
        o_checked    <= checked_count;
        o_pending    <= cells_due.size();
    end

endmodule

// ===== tb/tb_voxel_ray_dda_traversal_unit.sv =====
// ---------------------------------------------------------------------------
// Voxel ray DDA traversal testbench
// Sends ray start and step words under random sender gaps and receiver
// stalls across a range of cell sizes; a checker beside the block predicts
// and compares every result word.
// ---------------------------------------------------------------------------
module tb_voxel_ray_dda_traversal_unit;
    import vrdda_pkg::*;

    localparam int WORD_TARGET     = 1650;
    localparam int PHASES          = 9;
    localparam int HOLD_OFF_CYCLES = 150;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = CELL_SIZE_RESET;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    t_req             req         = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    t_res             res;

    int fail_count;
    int pending;
    int checked;
    bit quiet_tail   = 1'b0;
    bit hold_off_req = 1'b0;
    int starts_sent  = 0;
    int steps_sent   = 0;
    int sizes_used   = 1;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    voxel_ray_dda_traversal_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req         (req),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_res         (res)
    );

    vrdda_traversal_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req         (req),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_res         (res),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Receiver: short random stalls, or one long hold-off when asked.
    always begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            repeat (HOLD_OFF_CYCLES) begin
                @(negedge clk);
                out_stall = 1'b1;
            end
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge clk);
                out_stall = 1'b1;
            end
        end else begin
            @(negedge clk);
            out_stall = 1'b0;
        end
    end

    initial begin
        #48_000_000;
        $display("tb_voxel_ray_dda_traversal_unit: FAIL");
        $finish;
    end

    function automatic t_req ray_word(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        t_req w;
        w.req_type = REQ_START;
        w.origin_x = ox;
        w.origin_y = oy;
        w.origin_z = oz;
        w.dir_x    = dx;
        w.dir_y    = dy;
        w.dir_z    = dz;
        return w;
    endfunction

    // Step words carry random junk in the fields the block ignores.
    function automatic t_req step_word();
        t_req w;
        w = ray_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        w.req_type = REQ_STEP;
        return w;
    endfunction

    function automatic logic [31:0] pick_coord(logic [31:0] cs);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = 32'h7fff_ffff;
            2: v = 32'h8000_0000;
            3: v = '0;
            4: v = cs * ($urandom_range(0, 8) - 4);
            5: v = cs * ($urandom_range(0, 8) - 4) - 1;
            default: begin
                v = $urandom_range(0, 32'h000f_ffff);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_heading();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = $urandom;
            2: v = 32'h8000_0000;
            3: v = 32'h7fff_ffff;
            4: v = 32'd1;
            5: v = 32'h0001_0000;
            default: v = $urandom_range(1, 32'h0003_ffff);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    task automatic offer_word(t_req w);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                @(negedge clk);
                in_valid = 1'b0;
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        req      = w;
        do
            @(posedge clk);
        while (in_stall);
        if (w.req_type == REQ_START)
            starts_sent++;
        else
            steps_sent++;
    endtask

    task automatic settle_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_cell_size(logic [CFG_W-1:0] v);
        settle_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sizes_used++;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] cs_plan [PHASES];
        int               budget;
        int               mark;
        cs_plan = '{32'd1, 32'hffff_ffff, 32'd0, 32'h8000_0000, 32'h0000_4000,
                    32'd3, 32'd0, 32'd65536, 32'd0};
        cs_plan[6] = $urandom_range(1, 32'h0010_0000);
        cs_plan[8] = $urandom;
        budget     = (WORD_TARGET - 20) / PHASES;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A step before any start walks the reset state.
        offer_word(step_word());
        // Zero direction: every distance is infinite.
        offer_word(ray_word('0, '0, '0, '0, '0, '0));
        offer_word(step_word());
        offer_word(ray_word(32'h7fff_ffff, 32'h8000_0000, '0,
                            32'h7fff_ffff, 32'h8000_0000, 32'd1));
        repeat (3) offer_word(step_word());
        // Negative steps starting exactly on a boundary.
        offer_word(ray_word(32'h0003_0000, 32'hfffe_0000, 32'h0000_8000,
                            32'hffff_0000, 32'hffff_ffff, '0));
        repeat (3) offer_word(step_word());
        // Equal distances on all three axes.
        offer_word(ray_word(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                            32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        repeat (4) offer_word(step_word());
        offer_word(ray_word(32'hffff_ffff, 32'd1, 32'h8000_0000,
                            32'h8000_0001, 32'h0000_0100, 32'hffff_fffe));
        repeat (2) offer_word(step_word());

        for (int p = 0; p < PHASES; p++) begin
            write_cell_size(cs_plan[p]);
            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            mark = starts_sent + steps_sent;
            // The result side holds off while steps keep coming, so the block backs up.
            if (p == 1) begin
                hold_off_req = 1'b1;
                repeat (40) offer_word(step_word());
            end
            while (starts_sent + steps_sent - mark < budget) begin
                if ($urandom_range(0, 7) != 0)
                    offer_word(ray_word(pick_coord(cs_plan[p]), pick_coord(cs_plan[p]),
                                        pick_coord(cs_plan[p]), pick_heading(),
                                        pick_heading(), pick_heading()));
                repeat ($urandom_range(0, 30)) offer_word(step_word());
            end
        end

        settle_idle();
        repeat (20) @(negedge clk);
        $display("Covered %0d ray starts and %0d cell steps under %0d cell sizes,",
                 starts_sent, steps_sent, sizes_used);
        $display("with %0d result words compared against the predicted walk.", checked);
        if (fail_count == 0)
            $display("tb_voxel_ray_dda_traversal_unit: PASS");
        else
            $display("tb_voxel_ray_dda_traversal_unit: FAIL");
        $finish;
    end

endmodule

// ===== voxel_ray_dda_traversal_unit.f =====
+incdir+sv
sv/vrdda_pkg.sv
sv/vrdda_div.sv
sv/voxel_ray_dda_traversal_unit.sv
tb/vrdda_traversal_checker.sv
tb/tb_voxel_ray_dda_traversal_unit.sv
